@@ rtl/pdw_pkg.sv @@
// Shared types, codes and digit helpers for the power display digit writer.
package pdw_pkg;

  localparam logic [1:0] REQ_POWER = 2'd0;
  localparam logic [1:0] REQ_NA    = 2'd1;

  localparam logic [3:0] CODE_DASH  = 4'h0a;
  localparam logic [3:0] CODE_BLANK = 4'h0f;

  localparam logic [16:0] POWER_MAX = 17'd99999;
  localparam logic [6:0]  UNIT_MAX  = 7'd99;

  localparam logic [16:0] STEP_D5   = 17'd10000;
  localparam logic [16:0] STEP_D4   = 17'd1000;
  localparam logic [16:0] STEP_D3   = 17'd100;
  localparam logic [16:0] STEP_D2   = 17'd10;

  // Pipeline payload between the digit extraction stages.
  typedef struct packed {
    logic [1:0]  req;
    logic [6:0]  unit;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [3:0]  d5;
    logic [3:0]  d4;
    logic [3:0]  d3;
    logic [16:0] rem;
  } pl_t;

  // Eight digit codes, entry 0 goes to digit register 8.
  typedef logic [7:0][3:0] codes_t;

  // Decimal digit of v at weight step, valid while v < 10 * step.
  function automatic logic [3:0] pdw_digit(input logic [16:0] v, input logic [16:0] step);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 17'(k) * step) d = 4'(k);
    end
    return d;
  endfunction

  // Remainder after removing digit d at weight step.
  function automatic logic [16:0] pdw_rem(input logic [16:0] v, input logic [3:0] d,
                                          input logic [16:0] step);
    return v - {13'd0, d} * step;
  endfunction

endpackage

@@ rtl/pdw_if.sv @@
// Valid/ready channel interfaces for display requests and digit writes.
interface pdw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [6:0]  inverter_index;
  logic [16:0] power_watts;

  modport source (output valid, req_type, inverter_index, power_watts, input ready);
  modport sink   (input valid, req_type, inverter_index, power_watts, output ready);
endinterface

interface pdw_wr_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_address;
  logic [3:0] digit_code;
  logic       last_write;

  modport source (output valid, digit_address, digit_code, last_write, input ready);
  modport sink   (input valid, digit_address, digit_code, last_write, output ready);
endinterface

@@ rtl/power_display_digit_writer_unit.sv @@
// Top level: display request to eight digit-register writes.
//
// Usage
//   req_i carries one display request per item: request type, zero-based
//   unit number and power in watts. wr_o carries digit-register writes,
//   digit 8 first and digit 1 last; last_write marks the eighth write.
//   Every request yields exactly eight writes.
//
// Timing
//   A request passes five register stages (saturate, unit digits with the
//   ten-thousands digit, thousands, hundreds, then the last two power
//   digits with code assembly) and loads the write shifter. The shifter
//   sends one digit per cycle while the receiver holds ready high and
//   takes the next request only after the eighth write; the stages ahead
//   of it take a new request every cycle until they fill.
//
// Reset and stalls
//   rst_ni clears all valid bits and the shifter; no write is pending.
//   When the receiver holds ready low, the current write stays on the
//   port, the shifter holds, and the stages fill up and drop req_i.ready.
module power_display_digit_writer_unit
  import pdw_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  pdw_req_if.sink       req_i,
  pdw_wr_if.source      wr_o
);

  // Stage registers: payload plus valid bit per stage.
  pl_t    s1_q, s2_q, s3_q, s4_q;
  pl_t    s1_d, s2_d, s3_d, s4_d;
  logic   v1_q, v2_q, v3_q, v4_q, v5_q;
  codes_t s5_q, s5_d;

  // Write shifter.
  codes_t     codes_q;
  logic [2:0] cnt_q;
  logic       busy_q;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic wr_fire, wr_done, ser_free;

  // Stall chain: a stage takes new data when empty or when it moves on.
  assign wr_fire  = busy_q && wr_o.ready;
  assign wr_done  = wr_fire && (cnt_q == 3'd7);
  assign ser_free = !busy_q || wr_done;
  assign rdy5     = !v5_q || ser_free;
  assign rdy4     = !v4_q || rdy5;
  assign rdy3     = !v3_q || rdy4;
  assign rdy2     = !v2_q || rdy3;
  assign rdy1     = !v1_q || rdy2;
  assign req_i.ready = rdy1;

  // Stage 1: saturate unit number and power.
  logic [7:0] unit_inc;
  always_comb begin
    unit_inc  = {1'b0, req_i.inverter_index} + 8'd1;
    s1_d      = '0;
    s1_d.req  = req_i.req_type;
    s1_d.unit = (unit_inc > {1'b0, UNIT_MAX}) ? UNIT_MAX : unit_inc[6:0];
    s1_d.rem  = (req_i.power_watts > POWER_MAX) ? POWER_MAX : req_i.power_watts;
  end

  // Stage 2: unit tens and ones, ten-thousands digit.
  always_comb begin
    s2_d      = s1_q;
    s2_d.tens = pdw_digit({10'd0, s1_q.unit}, STEP_D2);
    s2_d.ones = 4'(pdw_rem({10'd0, s1_q.unit}, s2_d.tens, STEP_D2));
    s2_d.d5   = pdw_digit(s1_q.rem, STEP_D5);
    s2_d.rem  = pdw_rem(s1_q.rem, s2_d.d5, STEP_D5);
  end

  // Stage 3: thousands digit.
  always_comb begin
    s3_d     = s2_q;
    s3_d.d4  = pdw_digit(s2_q.rem, STEP_D4);
    s3_d.rem = pdw_rem(s2_q.rem, s3_d.d4, STEP_D4);
  end

  // Stage 4: hundreds digit.
  always_comb begin
    s4_d     = s3_q;
    s4_d.d3  = pdw_digit(s3_q.rem, STEP_D3);
    s4_d.rem = pdw_rem(s3_q.rem, s4_d.d3, STEP_D3);
  end

  // Stage 5: tens and ones of power, blanking, assemble the eight codes.
  logic [3:0] p_d2, p_d1;
  logic       b5, b4, b3;
  always_comb begin
    p_d2 = pdw_digit(s4_q.rem, STEP_D2);
    p_d1 = 4'(pdw_rem(s4_q.rem, p_d2, STEP_D2));
    b5   = (s4_q.d5 == 4'd0);
    b4   = b5 && (s4_q.d4 == 4'd0);
    b3   = b4 && (s4_q.d3 == 4'd0);
    case (s4_q.req)
      REQ_POWER: begin
        s5_d = {p_d1, p_d2,
                b3 ? CODE_BLANK : s4_q.d3,
                b4 ? CODE_BLANK : s4_q.d4,
                b5 ? CODE_BLANK : s4_q.d5,
                CODE_DASH, s4_q.ones, s4_q.tens};
      end
      REQ_NA: begin
        s5_d = {CODE_DASH, CODE_DASH, CODE_DASH, CODE_DASH, CODE_BLANK,
                CODE_DASH, s4_q.ones, s4_q.tens};
      end
      default: begin
        // Unused type shows all dashes too.
        s5_d = {8{CODE_DASH}};
      end
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) s3_q <= s3_d;
    if (rdy4) s4_q <= s4_d;
    if (rdy5) s5_q <= s5_d;
  end

  // Write shifter: load a finished request, advance one digit per taken write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      if (ser_free) begin
        busy_q <= v5_q;
        cnt_q  <= 3'd0;
      end else if (wr_fire) begin
        cnt_q  <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_free && v5_q) codes_q <= s5_q;
  end

  assign wr_o.valid         = busy_q;
  assign wr_o.digit_address = 4'd8 - {1'b0, cnt_q};
  assign wr_o.digit_code    = codes_q[cnt_q];
  assign wr_o.last_write    = (cnt_q == 3'd7);

  // Hold the shifter position while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !wr_o.ready |=> busy_q && $stable(cnt_q))
    else $error("write shifter moved during a stall");

  // Digit 6 is a dash in every mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (cnt_q == 3'd2) |-> wr_o.digit_code == CODE_DASH)
    else $error("digit 6 is not a dash");

  // Digits 2 and 1 are never blanked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (cnt_q == 3'd6 || cnt_q == 3'd7) |-> wr_o.digit_code != CODE_BLANK)
    else $error("low digit blanked");

  // A finished request is handed over right after the eighth write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_done |=> busy_q == $past(v5_q))
    else $error("queued request lost at shifter handover");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the power display digit writer: directed table, then random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdw_pkg::*;

  // The package names only the power and not-available requests; type 2 is
  // the all-dashes request and type 3 is unused, which the block treats as
  // all dashes too.
  localparam logic [1:0] REQ_DASHES = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  localparam int RANDOM_ITEMS   = 200;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int SETTLE_CYCLES  = 20;    // quiet time to watch for stray writes
  localparam int MAX_REPORTS    = 10;

  // One digit-register write as it appears on wr_o.
  typedef struct packed {
    logic [3:0] digit_address;
    logic [3:0] digit_code;
    logic       last_write;
  } digit_write_t;

  // One directed request. Where known_codes is set, codes holds the eight
  // code-B values typed in by hand, index = digit address (8 is written first).
  typedef struct packed {
    logic [1:0]       req_type;
    logic [6:0]       inverter_index;
    logic [16:0]      power_watts;
    logic             known_codes;
    logic [8:1][3:0]  codes;
  } display_row_t;

  localparam int DIRECTED_COUNT = 20;
  localparam display_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // extremes, read straight off the display format
    '{REQ_POWER,  7'd0,   17'd0,      1'b1, 32'h01AFFF00},  // zero power: two zeros
    '{REQ_POWER,  7'd98,  17'd99999,  1'b1, 32'h99A99999},  // largest shown values
    '{REQ_POWER,  7'd127, 17'd131071, 1'b1, 32'h99A99999},  // both fields saturate
    '{REQ_POWER,  7'd99,  17'd100000, 1'b1, 32'h99A99999},  // just past both limits
    '{REQ_NA,     7'd0,   17'd0,      1'b1, 32'h01AFAAAA},
    '{REQ_NA,     7'd127, 17'd131071, 1'b1, 32'h99AFAAAA},
    '{REQ_DASHES, 7'd5,   17'd1234,   1'b1, 32'hAAAAAAAA},
    '{REQ_SPARE,  7'd127, 17'd131071, 1'b1, 32'hAAAAAAAA},  // unused type = dashes
    // leading-zero blanking and digit boundaries, checked by the predictor
    '{REQ_POWER,  7'd9,   17'd5,      1'b0, 32'h0},  // unit ten
    '{REQ_POWER,  7'd1,   17'd10,     1'b0, 32'h0},
    '{REQ_POWER,  7'd2,   17'd100,    1'b0, 32'h0},
    '{REQ_POWER,  7'd3,   17'd1000,   1'b0, 32'h0},
    '{REQ_POWER,  7'd4,   17'd10000,  1'b0, 32'h0},
    '{REQ_POWER,  7'd5,   17'd10203,  1'b0, 32'h0},  // inner zeros stay visible
    '{REQ_POWER,  7'd6,   17'd1005,   1'b0, 32'h0},
    '{REQ_POWER,  7'd7,   17'd99,     1'b0, 32'h0},
    '{REQ_POWER,  7'd8,   17'd100001, 1'b0, 32'h0},
    '{REQ_POWER,  7'd10,  17'd65536,  1'b0, 32'h0},
    '{REQ_POWER,  7'd63,  17'd43690,  1'b0, 32'h0},
    '{REQ_NA,     7'd64,  17'd21845,  1'b0, 32'h0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  pdw_req_if req_if ();
  pdw_wr_if  wr_if ();

  power_display_digit_writer_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .wr_o   (wr_if)
  );

  always #5ns clk_i = ~clk_i;

  // Writes still owed by the block, oldest first.
  digit_write_t pending_writes [$];
  int unsigned  mismatch_count = 0;

  // Work out the eight code-B values that one request puts on the display.
  function automatic logic [8:1][3:0] display_codes(input logic [1:0]  req_type,
                                                    input logic [6:0]  inverter_index,
                                                    input logic [16:0] power_watts);
    logic [8:1][3:0] codes;
    int unsigned     unit_no;
    int unsigned     p;
    int unsigned     d5, d4, d3;
    logic            blank;
    codes   = {8{CODE_DASH}};
    unit_no = int'(inverter_index) + 1;
    if (unit_no > UNIT_MAX) unit_no = 32'(UNIT_MAX);
    if (req_type == REQ_POWER || req_type == REQ_NA) begin
      codes[8] = 4'(unit_no / 10);
      codes[7] = 4'(unit_no % 10);
    end
    if (req_type == REQ_POWER) begin
      p  = (power_watts > POWER_MAX) ? 32'(POWER_MAX) : 32'(power_watts);
      d5 = p / STEP_D5;
      d4 = (p / STEP_D4) % 10;
      d3 = (p / STEP_D3) % 10;
      codes[2] = 4'((p / STEP_D2) % 10);
      codes[1] = 4'(p % 10);
      // Blank a top digit only while every digit above it was blanked too.
      blank    = (d5 == 0);
      codes[5] = blank ? CODE_BLANK : 4'(d5);
      blank    = blank && (d4 == 0);
      codes[4] = blank ? CODE_BLANK : 4'(d4);
      blank    = blank && (d3 == 0);
      codes[3] = blank ? CODE_BLANK : 4'(d3);
    end else if (req_type == REQ_NA) begin
      codes[5] = CODE_BLANK;
    end
    return codes;
  endfunction

  // Queue the writes for one request: digit 8 first, last_write on digit 1.
  function automatic void queue_writes(input logic [8:1][3:0] codes);
    for (int a = 8; a >= 1; a--) begin
      pending_writes.push_back('{4'(a), codes[a], a == 1});
    end
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Power spread over every digit count, the saturation range, and values
  // built from digits that are often zero to exercise the blanking chain.
  function automatic logic [16:0] pick_power();
    int unsigned p;
    case ($urandom_range(0, 9))
      0: p = $urandom_range(0, 9);
      1: p = $urandom_range(10, 99);
      2: p = $urandom_range(100, 999);
      3: p = $urandom_range(1000, 9999);
      4, 5: p = $urandom_range(10000, 99999);
      6, 7: begin
        p = 0;
        repeat (5) p = p * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 9));
      end
      8: p = $urandom_range(100000, 131071);
      default: p = $urandom_range(0, 131071);
    endcase
    return 17'(p);
  endfunction

  // Offer one request, after an optional idle gap, and hold it until the
  // block takes it. Valid stays high into the next call when no gap follows.
  task automatic send_request(input logic [1:0]      req_type,
                              input logic [6:0]      inverter_index,
                              input logic [16:0]     power_watts,
                              input bit              steady,
                              input logic            known_codes,
                              input logic [8:1][3:0] codes);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= req_type;
    req_if.inverter_index <= inverter_index;
    req_if.power_watts    <= power_watts;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    // Accepted at this edge: record what the display must show.
    if (known_codes) queue_writes(codes);
    else queue_writes(display_codes(req_type, inverter_index, power_watts));
  endtask

  // Hold the sender until the block has delivered every owed write.
  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
  endtask

  // Request side: reset, directed table, random requests, then the verdict.
  initial begin
    logic [1:0] req_type;
    int         r;
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.req_type       = '0;
    req_if.inverter_index = '0;
    req_if.power_watts    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; first half with gaps, second half back-to-back.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_request(DIRECTED_ROWS[i].req_type, DIRECTED_ROWS[i].inverter_index,
                   DIRECTED_ROWS[i].power_watts, i >= DIRECTED_COUNT / 2,
                   DIRECTED_ROWS[i].known_codes, DIRECTED_ROWS[i].codes);
    end
    wait_for_drain();

    // Random requests, mostly power readings. Every third block of 32 runs
    // with no sender gaps so the block sees back-to-back traffic.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
      r = $urandom_range(0, 99);
      if (r < 70) req_type = REQ_POWER;
      else if (r < 85) req_type = REQ_NA;
      else if (r < 95) req_type = REQ_DASHES;
      else req_type = REQ_SPARE;
      send_request(req_type, 7'($urandom_range(0, 127)), pick_power(),
                   ((n / 32) % 3) == 1, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    // Let the last writes come out, then watch for stray ones.
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Write side: check each accepted write against the oldest owed one, and
  // stall at random, with a recurring quiet stretch in which ready stays high.
  initial begin
    digit_write_t got;
    digit_write_t want;
    int           stall_left;
    int unsigned  sink_cycles;
    stall_left   = 0;
    sink_cycles  = 0;
    wr_if.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (wr_if.valid && wr_if.ready) begin
          got = '{wr_if.digit_address, wr_if.digit_code, wr_if.last_write};
          if (pending_writes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("unexpected digit write: addr %0d code %h last %b",
                       got.digit_address, got.digit_code, got.last_write);
          end else begin
            want = pending_writes.pop_front();
            if (got !== want) begin
              mismatch_count++;
              if (mismatch_count <= MAX_REPORTS)
                $display({"digit write mismatch: expected addr %0d code %h last %b,",
                          " got addr %0d code %h last %b"},
                         want.digit_address, want.digit_code, want.last_write,
                         got.digit_address, got.digit_code, got.last_write);
            end
          end
        end
        sink_cycles++;
        if (stall_left > 0) begin
          wr_if.ready <= 1'b0;
          stall_left--;
        end else begin
          wr_if.ready <= 1'b1;
          if ((sink_cycles % 400) >= 100) stall_left = pick_gap();
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (wr_if.valid && wr_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ filelist.f @@
rtl/pdw_pkg.sv
rtl/pdw_if.sv
rtl/power_display_digit_writer_unit.sv
tb/tb.sv
